### sv/ahmb_pkg.sv
// Shared types, constants and helper functions for the aged histogram median background block.
package ahmb_pkg;

   // Field and register widths
   localparam int POS_W    = 10;
   localparam int SAMPLE_W = 8;
   localparam int RATE_W   = 17;
   localparam int W_W      = 48;
   localparam int BG_W     = 8;

   // Stream payload widths, padded to whole bytes
   localparam int REQ_TDATA_W = 24;
   localparam int RSP_TDATA_W = 24;

   // Default sizing
   localparam int POSITIONS_DEF = 1024;
   localparam int BINS_DEF      = 64;
   localparam int BIN_WIDTH_DEF = 4;

   // Q32.16 weight constants
   localparam logic [W_W-1:0]    WMAX     = {W_W{1'b1}};
   localparam logic [W_W-1:0]    ONE_Q16  = W_W'(65536);
   localparam logic [RATE_W-1:0] RATE_ONE = RATE_W'(65536);
   localparam logic [BG_W-1:0]   BG_MAX   = 8'd255;

   // Status of the frame weight unit
   typedef struct packed {
      logic           busy;
      logic [W_W-1:0] cur_weight;
      logic [W_W-1:0] total_weight;
   } age_stat_type;

   typedef logic [7:0] bin_lut_type [256];

   // Sample to bin table, built by counting so no divider is needed
   function automatic bin_lut_type bin_lut(input int bw);
      bin_lut_type lut;
      int bin;
      int cnt;
      bin = 0;
      cnt = 0;
      for (int i = 0; i < 256; i++) begin
         lut[i] = 8'(bin);
         cnt++;
         if (cnt == bw) begin
            cnt = 0;
            bin++;
         end
      end
      return lut;
   endfunction

endpackage

### sv/ahmb_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
module ahmb_ram #(
   parameter int WIDTH  = 8,
   parameter int DEPTH  = 2,
   parameter int ADDR_W = 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // read port, old data on a same-address collision
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### sv/ahmb_age.sv
// Frame weight unit: ages the current weight and accumulates the running total.
module ahmb_age (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          go,
   input  logic [ahmb_pkg::RATE_W-1:0]   rate,
   output ahmb_pkg::age_stat_type        stat
);

   localparam int W = ahmb_pkg::W_W;

   logic         ph1_ff, ph1_in;
   logic         ph2_ff, ph2_in;
   logic         seen_ff, seen_in;
   logic [W-1:0] cur_ff, cur_in;
   logic [W-1:0] tot_ff, tot_in;
   logic [W:0]   prod_hi_ff;
   logic [16:0]  prod_lo_ff;
   logic [32:0]  lo_full;
   logic [W+1:0] aged_sum;
   logic [W:0]   tot_sum;

   // split multiply: upper 32 bits and lower 16 bits by the rate
   assign lo_full  = 33'(cur_ff[15:0]) * 33'(rate);
   assign aged_sum = (W+2)'(prod_hi_ff) + (W+2)'(prod_lo_ff);
   assign tot_sum  = {1'b0, tot_ff} + {1'b0, cur_ff};

   always_ff @(posedge clock) begin
      if (go) begin
         prod_hi_ff <= (W+1)'(cur_ff[W-1:16]) * (W+1)'(rate);
         prod_lo_ff <= lo_full[32:16];
      end
   end

   // phase 1 saturates the aged weight, phase 2 adds it to the total
   always_comb begin
      ph1_in  = go;
      ph2_in  = ph1_ff;
      seen_in = seen_ff;
      cur_in  = cur_ff;
      tot_in  = tot_ff;
      if (ph1_ff && seen_ff) begin
         cur_in = (aged_sum > (W+2)'(ahmb_pkg::WMAX)) ? ahmb_pkg::WMAX : aged_sum[W-1:0];
      end
      if (ph2_ff) begin
         tot_in  = tot_sum[W] ? ahmb_pkg::WMAX : tot_sum[W-1:0];
         seen_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ph1_ff  <= 1'b0;
         ph2_ff  <= 1'b0;
         seen_ff <= 1'b0;
         cur_ff  <= ahmb_pkg::ONE_Q16;
         tot_ff  <= '0;
      end else begin
         ph1_ff  <= ph1_in;
         ph2_ff  <= ph2_in;
         seen_ff <= seen_in;
         cur_ff  <= cur_in;
         tot_ff  <= tot_in;
      end
   end

   assign stat.busy         = ph1_ff | ph2_ff;
   assign stat.cur_weight   = cur_ff;
   assign stat.total_weight = tot_ff;

endmodule

### sv/aged_histogram_median_background.sv
// Top level: per-position aged histogram with a walking running median.
//
//  channel | direction | handshake             | payload
//  req     | in        | req_tvalid/req_tready | tdata: position, sample; tuser: frame_start
//  rsp     | out       | rsp_tvalid/rsp_tready | tdata: out_position, background
//  csr     | in        | csr_valid/csr_ready   | data: per-frame weight multiplier, Q1.16
//
// An item passes through accept, histogram update, upward check and downward
// check when the median stays put, plus a wait on a frame start for the split
// multiply of the aging unit, plus an upward check per bin walked up and a
// downward check and subtract per bin walked down, each bin step one histogram RAM read.
// After reset a clearing pass over all POSITIONS*BINS addresses (65536 at the
// defaults) zeroes both RAMs; no item is taken meanwhile, csr writes are.
// A finished result sits in the output register; the next item is accepted while
// it waits, and that item's completion holds until the register is free.
module aged_histogram_median_background #(
   parameter int POSITIONS = ahmb_pkg::POSITIONS_DEF,
   parameter int BINS      = ahmb_pkg::BINS_DEF,
   parameter int BIN_WIDTH = ahmb_pkg::BIN_WIDTH_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   // position [9:0], sample [17:10], zero [23:18]
   input  logic [ahmb_pkg::REQ_TDATA_W-1:0]    req_tdata,
   // frame_start [0]
   input  logic                                req_tuser,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // out_position [9:0], background [17:10], zero [23:18]
   output logic [ahmb_pkg::RSP_TDATA_W-1:0]    rsp_tdata,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   input  logic [ahmb_pkg::RATE_W-1:0]         csr_data,
   input  logic                                csr_valid,
   output logic                                csr_ready
);

   localparam int W          = ahmb_pkg::W_W;
   localparam int PA         = (POSITIONS > 1) ? $clog2(POSITIONS) : 1;
   localparam int HIST_DEPTH = POSITIONS * BINS;
   localparam int HA         = $clog2(HIST_DEPTH);
   localparam int MW         = $clog2(BINS);
   localparam int PW         = W + MW;
   localparam logic [MW-1:0] M_TOP = MW'(BINS - 1);
   localparam logic [HA-1:0] CLR_LAST = HA'(HIST_DEPTH - 1);
   localparam ahmb_pkg::bin_lut_type BIN_LUT = ahmb_pkg::bin_lut(BIN_WIDTH);

   typedef enum logic [6:0] {
      S_CLEAR = 7'b0000001,
      S_IDLE  = 7'b0000010,
      S_FRAME = 7'b0000100,
      S_UPD   = 7'b0001000,
      S_UP    = 7'b0010000,
      S_DOWN  = 7'b0100000,
      S_SUB   = 7'b1000000
   } state_type;

   state_type state_ff, state_in;

   logic [HA-1:0]                    clr_cnt_ff, clr_cnt_in;
   logic [ahmb_pkg::RATE_W-1:0]      rate_ff;
   logic [ahmb_pkg::POS_W-1:0]       pos_ff;
   logic [ahmb_pkg::SAMPLE_W-1:0]    sample_ff;
   logic                             pos_ok_ff;
   logic [PA-1:0]                    idx_ff;
   logic [HA-1:0]                    base_ff;
   logic [MW-1:0]                    b_ff;
   logic [MW-1:0]                    m_ff, m_in;
   logic [W-1:0]                     below_ff, below_in;
   logic                             fwd_ff, fwd_in;
   logic [W-1:0]                     new_hist_ff, new_hist_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   logic [ahmb_pkg::POS_W-1:0]       rsp_pos_ff, rsp_pos_in;
   logic [ahmb_pkg::BG_W-1:0]        rsp_bg_ff, rsp_bg_in;

   // request decode
   logic [ahmb_pkg::POS_W-1:0]       req_pos;
   logic [ahmb_pkg::SAMPLE_W-1:0]    req_sample;
   logic [31:0]                      req_pos_wide;
   logic [PA-1:0]                    req_idx;
   logic                             req_pos_ok;
   logic [7:0]                       req_b_raw;
   logic [MW-1:0]                    req_b;
   logic [HA-1:0]                    req_base;
   logic                             accept;

   // RAM ports
   logic          hist_wr_en, hist_rd_en;
   logic [HA-1:0] hist_wr_addr, hist_rd_addr;
   logic [W-1:0]  hist_wr_data, hist_rd;
   logic          pos_wr_en, pos_rd_en;
   logic [PA-1:0] pos_wr_addr;
   logic [PW-1:0] pos_wr_data, pos_rd;

   // datapath
   ahmb_pkg::age_stat_type age_stat;
   logic          age_go;
   logic [MW-1:0] m_rd, m_cl;
   logic [W-1:0]  below_rd;
   logic [W:0]    hist_sum, below_sum;
   logic [W-1:0]  h;
   logic [W:0]    up_sum;
   logic          up_ok, down_ok, below_hit;
   logic [W-1:0]  up_sat, sub_val;
   logic [31:0]   bg_prod;
   logic [ahmb_pkg::BG_W-1:0] bg_val;
   logic          out_free;

   assign req_pos      = req_tdata[9:0];
   assign req_sample   = req_tdata[17:10];
   assign req_pos_wide = 32'(req_pos);
   assign req_idx      = req_pos_wide[PA-1:0];
   assign req_pos_ok   = req_pos_wide < 32'(POSITIONS);
   assign req_b_raw    = BIN_LUT[req_sample];
   assign req_b        = (32'(req_b_raw) > 32'(BINS - 1)) ? M_TOP : MW'(req_b_raw);
   assign req_base     = HA'(32'(req_idx) * 32'(BINS));

   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid & req_tready;
   assign csr_ready  = 1'b1;
   assign age_go     = accept & req_tuser;

   // configuration register
   always_ff @(posedge clock) begin
      if (reset) begin
         rate_ff <= ahmb_pkg::RATE_ONE;
      end else if (csr_valid) begin
         rate_ff <= csr_data;
      end
   end

   // latched request fields
   always_ff @(posedge clock) begin
      if (accept) begin
         pos_ff    <= req_pos;
         sample_ff <= req_sample;
         pos_ok_ff <= req_pos_ok;
         idx_ff    <= req_idx;
         base_ff   <= req_base;
         b_ff      <= req_b;
      end
   end

   // stored median and below-median weight for this position
   assign m_rd     = pos_rd[PW-1:W];
   assign below_rd = pos_rd[W-1:0];
   assign m_cl     = (32'(m_rd) > 32'(BINS - 1)) ? M_TOP : m_rd;

   // histogram update arithmetic
   assign hist_sum  = {1'b0, hist_rd} + {1'b0, age_stat.cur_weight};
   assign below_sum = {1'b0, below_rd} + {1'b0, age_stat.cur_weight};
   assign below_hit = 32'(sample_ff) < 32'(m_cl) * 32'(BIN_WIDTH);

   // walk arithmetic; first read after the update may hit the bin just written
   assign h       = fwd_ff ? new_hist_ff : hist_rd;
   assign up_sum  = {1'b0, below_ff} + {1'b0, h};
   assign up_ok   = (m_ff != M_TOP) &&
                    ({up_sum, 1'b0} < {2'b00, age_stat.total_weight});
   assign up_sat  = up_sum[W] ? ahmb_pkg::WMAX : up_sum[W-1:0];
   assign down_ok = (m_ff != '0) && ({below_ff, 1'b0} > {1'b0, age_stat.total_weight});
   assign sub_val = (below_ff > hist_rd) ? (below_ff - hist_rd) : '0;

   // background value
   assign bg_prod  = 32'(m_ff) * 32'(BIN_WIDTH);
   assign bg_val   = (bg_prod > 32'(ahmb_pkg::BG_MAX)) ? ahmb_pkg::BG_MAX : bg_prod[7:0];
   assign out_free = ~rsp_valid_ff | rsp_tready;

   // RAM read addresses follow the next median bin
   assign hist_rd_addr = (state_ff == S_IDLE) ? (req_base + HA'(req_b)) : (base_ff + HA'(m_in));

   // sequencer
   always_comb begin
      state_in     = state_ff;
      clr_cnt_in   = clr_cnt_ff;
      m_in         = m_ff;
      below_in     = below_ff;
      fwd_in       = fwd_ff;
      new_hist_in  = new_hist_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      rsp_pos_in   = rsp_pos_ff;
      rsp_bg_in    = rsp_bg_ff;
      hist_wr_en   = 1'b0;
      hist_wr_addr = base_ff + HA'(b_ff);
      hist_wr_data = new_hist_in;
      hist_rd_en   = 1'b0;
      pos_wr_en    = 1'b0;
      pos_wr_addr  = idx_ff;
      pos_wr_data  = {m_ff, below_ff};
      pos_rd_en    = 1'b0;
      case (state_ff)
         S_CLEAR: begin
            hist_wr_en   = 1'b1;
            hist_wr_addr = clr_cnt_ff;
            hist_wr_data = '0;
            pos_wr_en    = 32'(clr_cnt_ff) < 32'(POSITIONS);
            pos_wr_addr  = clr_cnt_ff[PA-1:0];
            pos_wr_data  = '0;
            clr_cnt_in   = clr_cnt_ff + 1'b1;
            if (clr_cnt_ff == CLR_LAST) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept) begin
               hist_rd_en = 1'b1;
               pos_rd_en  = 1'b1;
               state_in   = req_tuser ? S_FRAME : S_UPD;
            end
         end
         S_FRAME: begin
            if (!age_stat.busy) begin
               state_in = S_UPD;
            end
         end
         S_UPD: begin
            if (pos_ok_ff) begin
               new_hist_in  = hist_sum[W] ? ahmb_pkg::WMAX : hist_sum[W-1:0];
               hist_wr_en   = 1'b1;
               hist_wr_data = new_hist_in;
               below_in     = below_rd;
               if (below_hit) begin
                  below_in = below_sum[W] ? ahmb_pkg::WMAX : below_sum[W-1:0];
               end
               m_in       = m_cl;
               fwd_in     = (m_cl == b_ff);
               hist_rd_en = 1'b1;
               state_in   = S_UP;
            end else if (out_free) begin
               // position outside the frame: no state change, background 0
               rsp_valid_in = 1'b1;
               rsp_pos_in   = pos_ff;
               rsp_bg_in    = '0;
               state_in     = S_IDLE;
            end
         end
         S_UP: begin
            fwd_in = 1'b0;
            if (up_ok) begin
               below_in   = up_sat;
               m_in       = m_ff + 1'b1;
               hist_rd_en = 1'b1;
            end else begin
               state_in = S_DOWN;
            end
         end
         S_DOWN: begin
            if (down_ok) begin
               m_in       = m_ff - 1'b1;
               hist_rd_en = 1'b1;
               state_in   = S_SUB;
            end else if (out_free) begin
               pos_wr_en    = 1'b1;
               rsp_valid_in = 1'b1;
               rsp_pos_in   = pos_ff;
               rsp_bg_in    = bg_val;
               state_in     = S_IDLE;
            end
         end
         S_SUB: begin
            below_in = sub_val;
            state_in = S_DOWN;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
         fwd_ff       <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         fwd_ff       <= fwd_in;
      end
   end

   // walk and result payload
   always_ff @(posedge clock) begin
      m_ff        <= m_in;
      below_ff    <= below_in;
      new_hist_ff <= new_hist_in;
      rsp_pos_ff  <= rsp_pos_in;
      rsp_bg_ff   <= rsp_bg_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'b0, rsp_bg_ff, rsp_pos_ff};

   ahmb_age u_age (
      .clock (clock),
      .reset (reset),
      .go    (age_go),
      .rate  (rate_ff),
      .stat  (age_stat)
   );

   ahmb_ram #(
      .WIDTH  (W),
      .DEPTH  (HIST_DEPTH),
      .ADDR_W (HA)
   ) u_hist_ram (
      .clock   (clock),
      .wr_en   (hist_wr_en),
      .wr_addr (hist_wr_addr),
      .wr_data (hist_wr_data),
      .rd_en   (hist_rd_en),
      .rd_addr (hist_rd_addr),
      .rd_data (hist_rd)
   );

   ahmb_ram #(
      .WIDTH  (PW),
      .DEPTH  (POSITIONS),
      .ADDR_W (PA)
   ) u_pos_ram (
      .clock   (clock),
      .wr_en   (pos_wr_en),
      .wr_addr (pos_wr_addr),
      .wr_data (pos_wr_data),
      .rd_en   (pos_rd_en),
      .rd_addr (req_idx),
      .rd_data (pos_rd)
   );

endmodule

### sv/ahmb_checker.sv
// Port-level checker for the aged histogram median background block, with its bind.
module ahmb_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_tvalid,
   input logic                              req_tready,
   input logic [ahmb_pkg::RSP_TDATA_W-1:0]  rsp_tdata,
   input logic                              rsp_tvalid,
   input logic                              rsp_tready
);

   // a stalled result stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result dropped while stalled");

   // and keeps its payload
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata))
      else $error("result payload changed while stalled");

   // the clearing pass follows reset, so no item is taken right after it
   a_clear_after_reset: assert property (@(posedge clock)
      reset |=> !req_tready)
      else $error("item taken during clearing pass");

   // one item in work at a time
   a_one_in_work: assert property (@(posedge clock)
      req_tvalid && req_tready |=> !req_tready)
      else $error("second item taken while one is in work");

   // padding bits of the result stay zero
   a_rsp_pad: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[23:18] == 6'b0))
      else $error("result padding not zero");

endmodule

bind aged_histogram_median_background ahmb_checker u_ahmb_checker (.*);

### sim/tb.sv
// Self-checking testbench for the aged histogram running-median background block.
`timescale 1ns / 1ps

module tb;

   localparam int POSITIONS   = ahmb_pkg::POSITIONS_DEF;
   localparam int BINS        = ahmb_pkg::BINS_DEF;
   localparam int BIN_WIDTH   = ahmb_pkg::BIN_WIDTH_DEF;
   localparam int POS_W       = ahmb_pkg::POS_W;
   localparam int SAMPLE_W    = ahmb_pkg::SAMPLE_W;
   localparam int BG_W        = ahmb_pkg::BG_W;
   localparam int RATE_W      = ahmb_pkg::RATE_W;
   localparam int REQ_TDATA_W = ahmb_pkg::REQ_TDATA_W;
   localparam int RSP_TDATA_W = ahmb_pkg::RSP_TDATA_W;
   localparam int PHASE_ITEMS = 184;
   localparam int TAIL_CYCLES = 200;
   localparam int CYCLE_LIMIT = 1_500_000;
   localparam int RATE_MAX    = 131071;
   localparam int HOT_COUNT   = 6;

   localparam longint unsigned W_CEIL = (64'd1 << ahmb_pkg::W_W) - 64'd1;

   typedef longint unsigned wt_type;

   // One expected result item
   typedef struct {
      logic [POS_W-1:0] position;
      logic [BG_W-1:0]  background;
   } bg_expect_type;

   // One row of the directed walk; typed rows carry their known background
   typedef struct packed {
      logic [POS_W-1:0]    pos;
      logic [SAMPLE_W-1:0] smp;
      logic                fs;
      logic                typed;
      logic [BG_W-1:0]     bg;
   } walk_row_type;

   logic                   clock;
   logic                   reset;
   logic [REQ_TDATA_W-1:0] req_tdata;
   logic                   req_tuser;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic [RATE_W-1:0]      csr_data;
   logic                   csr_valid;
   logic                   csr_ready;

   // Shadow of the block's histogram state
   wt_type      bin_weight   [POSITIONS*BINS];
   wt_type      below_weight [POSITIONS];
   int unsigned med_idx      [POSITIONS];
   wt_type      frame_weight;
   wt_type      total_weight;
   wt_type      rate_q16;
   bit          aged_once;

   bg_expect_type pending_bg [$];
   int            fault_count;
   int            cycle_count;
   bit            no_gaps;

   walk_row_type walk_table [0:17] = '{
      '{10'd0,    8'd0,   1'b1, 1'b1, 8'd0},   // first item after reset
      '{10'd1023, 8'd255, 1'b0, 1'b1, 8'd252}, // walks all the way up
      '{10'd1023, 8'd0,   1'b0, 1'b1, 8'd0},   // walks all the way down
      '{10'd512,  8'd128, 1'b1, 1'b1, 8'd128}, // mid bin, second frame
      '{10'd512,  8'd255, 1'b0, 1'b0, 8'd0},
      '{10'd512,  8'd0,   1'b0, 1'b0, 8'd0},
      '{10'd512,  8'd3,   1'b0, 1'b0, 8'd0},
      '{10'd512,  8'd4,   1'b1, 1'b0, 8'd0},
      '{10'd341,  8'd170, 1'b0, 1'b0, 8'd0},
      '{10'd682,  8'd85,  1'b1, 1'b0, 8'd0},
      '{10'd341,  8'd251, 1'b0, 1'b0, 8'd0},
      '{10'd341,  8'd252, 1'b0, 1'b0, 8'd0},
      '{10'd0,    8'd255, 1'b0, 1'b0, 8'd0},
      '{10'd0,    8'd255, 1'b1, 1'b0, 8'd0},
      '{10'd0,    8'd255, 1'b0, 1'b0, 8'd0},
      '{10'd1023, 8'd128, 1'b1, 1'b0, 8'd0},
      '{10'd1,    8'd1,   1'b0, 1'b0, 8'd0},
      '{10'd1022, 8'd254, 1'b1, 1'b0, 8'd0}
   };

   aged_histogram_median_background dut (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_data   (csr_data),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Saturating weight arithmetic
   function automatic wt_type wsum(input wt_type a, input wt_type b);
      wt_type s;
      s = a + b;
      return (s > W_CEIL) ? W_CEIL : s;
   endfunction

   function automatic wt_type wdiff(input wt_type a, input wt_type b);
      return (a > b) ? a - b : 64'd0;
   endfunction

   // Idle length: mostly none, some short, a few long
   function automatic int pick_gap();
      int r;
      if (no_gaps) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(4, 40);
   endfunction

   // Apply one sample to the shadow histogram, return the new background
   function automatic logic [BG_W-1:0] track_median(input int unsigned pos,
                                                     input int unsigned smp,
                                                     input bit fs);
      wt_type      below;
      wt_type      prod;
      int unsigned m;
      int unsigned b;
      int unsigned base;
      int unsigned bg;
      if (fs) begin
         if (aged_once) begin
            prod = (frame_weight >> 16) * rate_q16
                 + (((frame_weight & 64'hFFFF) * rate_q16) >> 16);
            frame_weight = (prod > W_CEIL) ? W_CEIL : prod;
         end
         total_weight = wsum(total_weight, frame_weight);
         aged_once = 1'b1;
      end
      if (pos >= POSITIONS) return '0;
      base  = pos * BINS;
      below = below_weight[pos];
      m     = med_idx[pos];
      if (m >= BINS) m = BINS - 1;
      b = smp / BIN_WIDTH;
      if (b >= BINS) b = BINS - 1;
      bin_weight[base+b] = wsum(bin_weight[base+b], frame_weight);
      if (smp < m * BIN_WIDTH) below = wsum(below, frame_weight);
      // walk up while the weight at or below the median is under half
      while (m < BINS - 1 && 2 * (below + bin_weight[base+m]) < total_weight) begin
         below = wsum(below, bin_weight[base+m]);
         m++;
      end
      // walk down while the weight below it is over half
      while (m > 0 && 2 * below > total_weight) begin
         m--;
         below = wdiff(below, bin_weight[base+m]);
      end
      below_weight[pos] = below;
      med_idx[pos]      = m;
      bg = m * BIN_WIDTH;
      if (bg > 255) bg = 255;
      return BG_W'(bg);
   endfunction

   // Drive one sample item; a typed background of -1 defers to the shadow model
   task automatic send_sample(input logic [POS_W-1:0] pos, input logic [SAMPLE_W-1:0] smp,
                              input logic fs, input int typed_bg);
      int            gap;
      bg_expect_type e;
      gap = pick_gap();
      if (gap > 0) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_tdata  <= REQ_TDATA_W'({smp, pos});
      req_tuser  <= fs;
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      e.position   = pos;
      e.background = track_median(pos, smp, fs);
      if (typed_bg >= 0) e.background = BG_W'(typed_bg);
      pending_bg.push_back(e);
   endtask

   // Stop sending and wait until every expected item has come back
   task automatic finish_batch();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_bg.size() != 0) @(posedge clock);
   endtask

   task automatic write_rate(input int unsigned v);
      @(negedge clock);
      csr_data  <= RATE_W'(v);
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      rate_q16 = v;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Result side: random back-pressure
   initial begin : rsp_sink
      int hold;
      hold       = 0;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold > 0) begin
            rsp_tready <= 1'b0;
            hold--;
         end else begin
            rsp_tready <= 1'b1;
            hold = pick_gap();
         end
      end
   end

   // Compare each accepted result with the oldest expectation
   always @(posedge clock) begin : rsp_check
      bg_expect_type    want;
      logic [POS_W-1:0] got_pos;
      logic [BG_W-1:0]  got_bg;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got_pos = rsp_tdata[POS_W-1:0];
         got_bg  = rsp_tdata[POS_W +: BG_W];
         if (pending_bg.size() == 0) begin
            fault_count++;
            if (fault_count <= 10)
               $display("unexpected result: position %0d background %0d", got_pos, got_bg);
         end else begin
            want = pending_bg.pop_front();
            if (got_pos !== want.position || got_bg !== want.background) begin
               fault_count++;
               if (fault_count <= 10)
                  $display("result wrong: expected position %0d background %0d, got %0d %0d",
                           want.position, want.background, got_pos, got_bg);
            end
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   initial begin : stimulus
      int unsigned rate_plan [6];
      int unsigned hot_pos   [HOT_COUNT];
      int unsigned hot_level [HOT_COUNT];
      int          fs_odds;
      int          k;
      int          lvl;
      int unsigned pos;
      int unsigned smp;
      bit          fs;

      reset        = 1'b1;
      req_tdata    = '0;
      req_tuser    = 1'b0;
      req_tvalid   = 1'b0;
      csr_data     = '0;
      csr_valid    = 1'b0;
      fault_count  = 0;
      cycle_count  = 0;
      no_gaps      = 1'b0;
      frame_weight = 64'd65536;
      total_weight = 64'd0;
      rate_q16     = 64'd65536;
      aged_once    = 1'b0;

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed walk at unity aging
      write_rate(ahmb_pkg::RATE_ONE);
      foreach (walk_table[i])
         send_sample(walk_table[i].pos, walk_table[i].smp, walk_table[i].fs,
                     walk_table[i].typed ? int'(walk_table[i].bg) : -1);
      finish_batch();

      // Random phases: slow decay, unity, fastest growth, decay from saturation,
      // a random rate, then zero weight
      rate_plan = '{64000, ahmb_pkg::RATE_ONE, RATE_MAX, 40000,
                    $urandom_range(1, RATE_MAX - 1), 0};
      for (int ph = 0; ph < 6; ph++) begin
         no_gaps = (ph == 1);
         fs_odds = (ph == 2) ? 3 : 10;
         write_rate(rate_plan[ph]);
         for (int h = 0; h < HOT_COUNT; h++) begin
            hot_pos[h]   = $urandom_range(0, POSITIONS - 1);
            hot_level[h] = $urandom_range(0, 255);
         end
         repeat (PHASE_ITEMS) begin
            fs = ($urandom_range(0, fs_odds - 1) == 0);
            if ($urandom_range(0, 99) < 85) begin
               // a few busy positions with a drifting level
               k = $urandom_range(0, HOT_COUNT - 1);
               if ($urandom_range(0, 99) < 3) hot_level[k] = $urandom_range(0, 255);
               pos = hot_pos[k];
               if ($urandom_range(0, 99) < 75) begin
                  lvl = int'(hot_level[k]) + int'($urandom_range(0, 12)) - 6;
                  if (lvl < 0) lvl = 0;
                  if (lvl > 255) lvl = 255;
                  smp = lvl;
               end else begin
                  smp = $urandom_range(0, 255);
               end
            end else begin
               pos = $urandom_range(0, POSITIONS - 1);
               smp = $urandom_range(0, 255);
            end
            send_sample(pos, smp, fs, -1);
         end
         finish_batch();
      end

      no_gaps = 1'b0;
      repeat (TAIL_CYCLES) @(posedge clock);
      fault_count += pending_bg.size();
      if (fault_count == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

### aged_histogram_median_background.f
sv/ahmb_pkg.sv
sv/ahmb_ram.sv
sv/ahmb_age.sv
sv/aged_histogram_median_background.sv
sv/ahmb_checker.sv
sim/tb.sv
